>>> hw/rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants
// Widths, limits and register indexes for the blob centroid block.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int MaxLabels = 32;
  localparam int CoordBits = 10;
  localparam int SlotBits  = $clog2(MaxLabels);
  localparam int SumBits   = 30;
  localparam int CntBits   = 21;
  localparam int DivSteps  = SumBits;

  localparam logic [2:0] RegNumLabels  = 3'd0;
  localparam logic [2:0] RegFrameWidth = 3'd1;
  localparam logic [2:0] RegFrameHeight = 3'd2;
  localparam logic [2:0] RegMinSize    = 3'd3;
  localparam logic [2:0] RegMaxSize    = 3'd4;

  localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};

  // Front-to-back queue entry: one pixel's accumulate op, with an end-of-frame flag.
  typedef struct packed {
    logic                eof;
    logic                hit;
    logic [SlotBits-1:0] slot;
    logic [CoordBits-1:0] col;
    logic [CoordBits-1:0] row;
  } op_t;

  typedef struct packed {
    logic                found;
    logic [5:0]          label_index;
    logic [CoordBits-1:0] center_x;
    logic [CoordBits-1:0] center_y;
    logic [CntBits-1:0]  pixel_count;
    logic                last;
  } result_t;

endpackage

>>> hw/rtl/lbc_if.sv
// ----------------------------------------------------------------------------
// lbc_if: valid/ready channels
// Pixel, result and configuration channels of the blob centroid block.
// ----------------------------------------------------------------------------
interface lbc_pixel_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_label;
  modport source (output valid, output pixel_label, input ready);
  modport sink (input valid, input pixel_label, output ready);
endinterface

interface lbc_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  label_index;
  logic [9:0]  center_x;
  logic [9:0]  center_y;
  logic [20:0] pixel_count;
  logic        last;
  modport source (output valid, output found, output label_index, output center_x,
                  output center_y, output pixel_count, output last, input ready);
  modport sink (input valid, input found, input label_index, input center_x,
                input center_y, input pixel_count, input last, output ready);
endinterface

interface lbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [20:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/labeled_blob_centroid.sv
// ----------------------------------------------------------------------------
// labeled_blob_centroid: per-label centroid accumulator
// Sums coordinates per label over a frame and emits surviving centroids.
// ----------------------------------------------------------------------------
// Channels: pix (sink) takes one signed 9-bit label per item in raster order;
// res (source) returns result items; cfg (sink) writes the five registers
// (num_labels, line_pixels, frame_lines, min_size, max_size) by index.
// Throughput: one pixel per cycle while accumulating. A two-entry queue
// parts the classifier from the accumulator.
// A frame's last pixel waits while a result is still held; once it is
// taken the back end compacts the slots, then runs a serial divider per
// survivor and emits its result item. A clear sweep follows the last
// result. During that emission and clearing at most two pixels are taken
// into the queue; after that the source stalls.
// Reset: registers take their defaults, counters clear and a clear sweep of
// the sums runs before the first pixel is accumulated.
// A stalled receiver holds the current result and pauses the emission;
// pixels back up into the queue and then stall the source.
// ----------------------------------------------------------------------------
module labeled_blob_centroid (
  input logic         clk,
  input logic         rst,
  lbc_pixel_if.sink   pix,
  lbc_result_if.source res,
  lbc_cfg_if.sink     cfg
);
  import lbc_pkg::*;

  logic [6:0]  num_labels;
  logic [10:0] line_pixels, frame_lines;
  logic [20:0] min_size, max_size;

  // Hold config registers; ignore writes beyond the list.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_labels   <= 7'd32;
      line_pixels  <= 11'd640;
      frame_lines  <= 11'd480;
      min_size     <= 21'd20;
      max_size     <= 21'd2500;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegNumLabels:   num_labels   <= cfg.data[6:0];
        RegFrameWidth:  line_pixels  <= cfg.data[10:0];
        RegFrameHeight: frame_lines  <= cfg.data[10:0];
        RegMinSize:     min_size     <= cfg.data;
        RegMaxSize:     max_size     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front end and its queue.
  op_t  f_op, q_op [2], b_op;
  logic f_valid, f_ready, b_ready;
  logic [1:0] q_cnt;
  logic q_rd, q_wr;

  lbc_front u_front (
    .clk, .rst,
    .in_valid(pix.valid), .in_ready(pix.ready), .pixel_label(pix.pixel_label),
    .num_labels, .line_pixels, .frame_lines,
    .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
  );

  // Two-entry queue: head in slot 0.
  assign f_ready = (q_cnt != 2'd2);
  assign q_wr    = f_valid && f_ready;
  assign q_rd    = (q_cnt != 2'd0) && b_ready;
  assign b_op    = q_op[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt + {1'b0, q_wr} - {1'b0, q_rd};
      if (q_rd) begin
        // Advance the head; a new item lands there when it would be alone.
        if (q_wr && q_cnt == 2'd1) q_op[0] <= f_op;
        else q_op[0] <= q_op[1];
        if (q_wr && q_cnt == 2'd2) q_op[1] <= f_op;
      end else if (q_wr) begin
        if (q_cnt == 2'd0) q_op[0] <= f_op;
        else q_op[1] <= f_op;
      end
    end
  end

  result_t r;
  lbc_back u_back (
    .clk, .rst,
    .op_valid(q_cnt != 2'd0), .op_ready(b_ready), .op(b_op),
    .num_labels, .min_size, .max_size,
    .res_valid(res.valid), .res_ready(res.ready), .res(r)
  );

  assign res.found       = r.found;
  assign res.label_index = r.label_index;
  assign res.center_x    = r.center_x;
  assign res.center_y    = r.center_y;
  assign res.pixel_count = r.pixel_count;
  assign res.last        = r.last;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 2'd2) else $error("queue overflow");
  a_q_full: assert property (@(posedge clk) disable iff (rst)
    (q_cnt == 2'd2) |-> !f_ready) else $error("push into full queue");
  a_last_found: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.found) |-> res.last) else $error("empty result not last");
`endif

endmodule

>>> hw/rtl/lbc_front.sv
// ----------------------------------------------------------------------------
// lbc_front: pixel classifier
// Tracks column and row, classifies each label and pushes an op per pixel.
// ----------------------------------------------------------------------------
module lbc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [8:0]         pixel_label,
  input  logic [6:0]         num_labels,
  input  logic [10:0]        line_pixels,
  input  logic [10:0]        frame_lines,
  output logic               op_valid,
  input  logic               op_ready,
  output lbc_pkg::op_t       op
);
  import lbc_pkg::*;

  logic [CoordBits-1:0] column, row;
  logic [6:0]  n_eff;
  logic [11:0] w_eff, h_eff;
  logic        end_row, end_frame, fire;

  always_comb begin
    n_eff = (num_labels > 7'(MaxLabels)) ? 7'(MaxLabels) : num_labels;
    w_eff = (line_pixels == 11'd0) ? 12'd1 :
            (line_pixels > 11'(1 << CoordBits)) ? 12'(1 << CoordBits) : {1'b0, line_pixels};
    h_eff = (frame_lines == 11'd0) ? 12'd1 :
            (frame_lines > 11'(1 << CoordBits)) ? 12'(1 << CoordBits) : {1'b0, frame_lines};
    end_row   = (12'(column) + 12'd1) >= w_eff;
    end_frame = end_row && ((12'(row) + 12'd1) >= h_eff);
  end

  assign in_ready = op_ready;
  assign op_valid = in_valid;
  assign fire     = in_valid && op_ready;

  always_comb begin
    op.eof  = end_frame;
    op.hit  = !pixel_label[8] && ({1'b0, pixel_label[7:0]} < {2'b0, n_eff});
    op.slot = pixel_label[SlotBits-1:0];
    op.col  = column;
    op.row  = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (fire) begin
      if (end_frame) begin
        column <= '0;
        row    <= '0;
      end else if (end_row) begin
        column <= '0;
        row    <= row + 1'b1;
      end else begin
        column <= column + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/lbc_back.sv
// ----------------------------------------------------------------------------
// lbc_back: accumulator and end-of-frame emitter
// Holds per-slot sums, compacts at frame end and divides out centroids.
// ----------------------------------------------------------------------------
module lbc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  lbc_pkg::op_t       op,
  input  logic [6:0]         num_labels,
  input  logic [20:0]        min_size,
  input  logic [20:0]        max_size,
  output logic               res_valid,
  input  logic               res_ready,
  output lbc_pkg::result_t   res
);
  import lbc_pkg::*;

  localparam logic [2:0] StAcc   = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StOut   = 3'd3;
  localparam logic [2:0] StClear = 3'd4;

  logic [2:0] state;
  logic [SumBits-1:0]  sx [MaxLabels];
  logic [SumBits-1:0]  sy [MaxLabels];
  logic [CntBits-1:0]  ct [MaxLabels];
  logic [5:0]          lab [MaxLabels];
  logic [SlotBits:0]   live, idx, clr;
  logic [SlotBits-1:0] cur, tail;
  logic [6:0]          n_eff;
  logic                keep;
  logic                res_free, res_load;
  logic [5:0]          step;
  logic [SumBits-1:0]  qx, qy, nx, ny;
  logic [CntBits:0]    rx, ry, rx_s, ry_s;

  assign n_eff = (num_labels > 7'(MaxLabels)) ? 7'(MaxLabels) : num_labels;
  assign cur   = idx[SlotBits-1:0];
  assign tail  = SlotBits'(live - 1'b1);
  assign keep  = !(ct[cur] < min_size || ct[cur] > max_size);
  assign op_ready = (state == StAcc) && !(op.eof && res_valid);

  // Load the result register when it is free and an item is ready to go.
  assign res_free = !res_valid || res_ready;
  assign res_load = res_free && ((state == StOut) || ((state == StScan) && (live == '0)));

  // Restoring divide, one quotient bit of x and y per cycle.
  always_comb begin
    rx_s = {rx[CntBits-1:0], nx[SumBits-1]};
    ry_s = {ry[CntBits-1:0], ny[SumBits-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StClear;
      clr       <= '0;
      res_valid <= 1'b0;
      idx       <= '0;
      live      <= '0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      case (state)
        StAcc: begin
          if (op_valid && op_ready) begin
            if (op.hit) begin
              sx[op.slot] <= sx[op.slot] + SumBits'(op.col);
              sy[op.slot] <= sy[op.slot] + SumBits'(op.row);
              if (ct[op.slot] != CntMax) ct[op.slot] <= ct[op.slot] + 1'b1;
            end
            if (op.eof) begin
              state <= StScan;
              idx   <= '0;
              live  <= (SlotBits+1)'(n_eff);
              for (int k = 0; k < MaxLabels; k++) lab[k] <= 6'(k);
            end
          end
        end
        StScan: begin
          if (idx < live) begin
            if (!keep) begin
              sx[cur]  <= sx[tail];
              sy[cur]  <= sy[tail];
              ct[cur]  <= ct[tail];
              lab[cur] <= lab[tail];
              live     <= live - 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (live == '0) begin
            if (res_free) begin
              res       <= '{found: 1'b0, label_index: '0, center_x: '0, center_y: '0,
                             pixel_count: '0, last: 1'b1};
              state     <= StClear;
              clr       <= '0;
            end
          end else begin
            idx   <= '0;
            step  <= '0;
            nx    <= sx[0];
            ny    <= sy[0];
            rx    <= '0;
            ry    <= '0;
            state <= StDiv;
          end
        end
        StDiv: begin
          nx <= {nx[SumBits-2:0], 1'b0};
          ny <= {ny[SumBits-2:0], 1'b0};
          if (rx_s >= {1'b0, ct[cur]}) begin
            rx <= rx_s - {1'b0, ct[cur]};
            qx <= {qx[SumBits-2:0], 1'b1};
          end else begin
            rx <= rx_s;
            qx <= {qx[SumBits-2:0], 1'b0};
          end
          if (ry_s >= {1'b0, ct[cur]}) begin
            ry <= ry_s - {1'b0, ct[cur]};
            qy <= {qy[SumBits-2:0], 1'b1};
          end else begin
            ry <= ry_s;
            qy <= {qy[SumBits-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 6'(DivSteps - 1)) state <= StOut;
        end
        StOut: begin
          if (res_free) begin
            res.found       <= 1'b1;
            res.label_index <= lab[cur];
            res.center_x    <= (ct[cur] == '0) ? '0 : qx[CoordBits-1:0];
            res.center_y    <= (ct[cur] == '0) ? '0 : qy[CoordBits-1:0];
            res.pixel_count <= ct[cur];
            res.last        <= (idx + 1'b1 == live);
            if (idx + 1'b1 == live) begin
              state <= StClear;
              clr   <= '0;
            end else begin
              idx   <= idx + 1'b1;
              step  <= '0;
              nx    <= sx[SlotBits'(idx + 1'b1)];
              ny    <= sy[SlotBits'(idx + 1'b1)];
              rx    <= '0;
              ry    <= '0;
              state <= StDiv;
            end
          end
        end
        StClear: begin
          sx[clr[SlotBits-1:0]] <= '0;
          sy[clr[SlotBits-1:0]] <= '0;
          ct[clr[SlotBits-1:0]] <= '0;
          clr <= clr + 1'b1;
          if (clr == (SlotBits+1)'(MaxLabels - 1)) state <= StAcc;
        end
        default: state <= StClear;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StAcc) |-> !op_ready) else $error("op taken outside accumulate");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    (live <= (SlotBits+1)'(MaxLabels))) else $error("live count overflow");
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == StScan) |-> (idx <= live)) else $error("scan index past live");
`endif

endmodule
